FILE: hw/rtl/assert_macros.svh
// Assertion helper macros shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication check, disabled while the active-low reset is asserted.
`define SFOD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same check, evaluated during reset as well.
`define SFOD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: hw/rtl/sfod_pkg.sv
// ----------------------------------------------------------------------------
// sfod_pkg
// Shared constants for the spectral flux onset detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sfod_pkg;
  localparam int FftSizeDef   = 512;
  localparam int CompW        = 16;
  localparam int MagW         = 17;
  localparam int AccW         = 24;
  localparam int TotW         = 25;
  localparam int CdW          = 8;
  localparam int CfgIdxW      = 1;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgCooldown  = 1'b1;
  localparam logic [TotW-1:0] ThreshReset = 25'd3277;
  localparam logic [CdW-1:0]  CdReset     = 8'd10;
endpackage

FILE: hw/rtl/sfod_isqrt.sv
// ----------------------------------------------------------------------------
// sfod_isqrt
// Digit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sfod_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] radicand,
  output logic        done,
  output logic [15:0] root
);
  import sfod_pkg::*;

  logic [31:0] rad_r, rad_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [15:0] root_r, root_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [17:0] trial;
  logic [17:0] shifted;

  // restoring method: bring down two bits, try 4*root+1
  always_comb begin
    shifted  = {rem_r[15:0], rad_r[31:30]};
    trial    = {root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = 5'd16;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[29:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt  = shifted - trial;
        root_nxt = {root_r[14:0], 1'b1};
      end else begin
        rem_nxt  = shifted;
        root_nxt = {root_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

FILE: hw/rtl/spectral_flux_onset_detector.sv
// ----------------------------------------------------------------------------
// spectral_flux_onset_detector
// Per-bin stereo magnitude, positive spectral flux in two bands, onset flag.
// ----------------------------------------------------------------------------
// Channel | Signals                         | Direction | Content
// in      | in_tvalid/tready/tdata/tlast    | slave     | one stereo bin
// out     | out_tvalid/tready/tdata         | master    | frame flux result
// cfg     | cfg_we/cfg_idx/cfg_wdata        | slave     | register writes
//
// Each bin has its four components squared and summed per channel, each sum going
// to a 16-step digit-serial square root; a frame end adds the hold and frame states.
// One bin is in flight at a time; the output register frees the core so the
// next bin is taken while a result waits, unless a second result would stack.
// After reset the magnitude store is swept clear entry by entry, and no input
// bin is accepted until the sweep is done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module spectral_flux_onset_detector #(
  parameter int FFT_SIZE = sfod_pkg::FftSizeDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // left_re[15:0], left_im[31:16], right_re[47:32], right_im[63:48]
  input  logic [63:0]                   in_tdata,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // total_flux[24:0], high_flux[48:25], low_flux[72:49], onset[73], zero fill
  output logic [79:0]                   out_tdata,
  input  logic                          cfg_we,
  input  logic [sfod_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [sfod_pkg::TotW-1:0]     cfg_wdata
);
  import sfod_pkg::*;

  localparam int NumBins = FFT_SIZE / 2 + 1;
  localparam int LastBin = FFT_SIZE / 2;
  localparam int BinW    = $clog2(NumBins);
  localparam int CntW    = BinW + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SQ, S_RT_L, S_RT_R, S_ACC, S_FRAME, S_HOLD
  } state_t;

  state_t state_r;
  logic [BinW-1:0] clr_r;
  logic [CntW-1:0] bin_r;
  logic [AccW-1:0] high_r, low_r;
  logic [CdW-1:0]  cd_r, cdf_r;
  logic [TotW-1:0] thr_r;
  logic [CompW-1:0] lre_r, lim_r, rre_r, rim_r;
  logic            last_r, act_r;
  logic [1:0]      sq_r;
  logic [31:0]     rad_r, sqv_r;
  logic [MagW-1:0] mag_r, prev_r;
  logic [15:0]     lmag_r;
  logic            rt_go_r;
  logic            rt_done;
  logic [15:0]     rt_root;
  logic [MagW-1:0] mem [NumBins];
  logic [79:0]     otd_r;
  logic            ov_r;

  sfod_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(rt_go_r), .radicand(rad_r),
    .done(rt_done), .root(rt_root)
  );

  // squaring one component per cycle, registered
  logic signed [CompW-1:0] sq_in;
  logic [31:0] sq_prod;
  always_comb begin
    case (sq_r)
      2'd0:    sq_in = lre_r;
      2'd1:    sq_in = lim_r;
      2'd2:    sq_in = rre_r;
      default: sq_in = rim_r;
    endcase
    sq_prod = 32'(sq_in * sq_in);
  end

  logic [MagW-1:0] rise;
  logic [AccW:0]   acc_sum;
  logic            in_high, in_low;
  assign rise    = (mag_r > prev_r) ? mag_r - prev_r : '0;
  assign in_high = (bin_r >= CntW'(FFT_SIZE / 4)) && (bin_r < CntW'(LastBin));
  assign in_low  = (bin_r >= CntW'(1)) && (bin_r < CntW'(FFT_SIZE / 8));
  assign acc_sum = {1'b0, (in_high ? high_r : low_r)} + (AccW + 1)'(rise);

  logic [TotW-1:0] total;
  logic [CdW-1:0]  cd_dec;
  assign total  = (TotW)'(high_r) + (TotW)'(low_r);
  assign cd_dec = (cd_r != '0) ? cd_r - 8'd1 : cd_r;

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = otd_r;

  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) mem[clr_r] <= '0;
    else if (state_r == S_ACC && act_r) mem[bin_r[BinW-1:0]] <= mag_r;
    if (state_r == S_SQ) prev_r <= mem[bin_r[BinW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      bin_r   <= '0;
      high_r  <= '0;
      low_r   <= '0;
      cd_r    <= '0;
      thr_r   <= ThreshReset;
      cdf_r   <= CdReset;
      rt_go_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      rt_go_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_idx)
          CfgThreshold: thr_r <= cfg_wdata;
          CfgCooldown:  cdf_r <= cfg_wdata[CdW-1:0];
          default: ;
        endcase
      end
      if (ov_r && out_tready) ov_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + BinW'(1);
          if (clr_r == BinW'(LastBin)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid) begin
            {rim_r, rre_r, lim_r, lre_r} <= in_tdata;
            last_r  <= in_tlast;
            act_r   <= (bin_r <= CntW'(LastBin));
            sq_r    <= 2'd0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          sq_r <= sq_r + 2'd1;
          case (sq_r)
            2'd0: sqv_r <= sq_prod;
            2'd1: begin rad_r <= sqv_r + sq_prod; rt_go_r <= 1'b1; end
            2'd2: sqv_r <= sq_prod;
            default: begin
              sqv_r   <= sqv_r + sq_prod;
              state_r <= S_RT_L;
            end
          endcase
        end
        S_RT_L: begin
          if (rt_done) begin
            lmag_r  <= rt_root;
            rad_r   <= sqv_r;
            rt_go_r <= 1'b1;
            state_r <= S_RT_R;
          end
        end
        S_RT_R: begin
          if (rt_done) begin
            mag_r   <= {1'b0, lmag_r} + {1'b0, rt_root};
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (act_r) begin
            if (in_high)
              high_r <= acc_sum[AccW] ? '1 : acc_sum[AccW-1:0];
            else if (in_low)
              low_r <= acc_sum[AccW] ? '1 : acc_sum[AccW-1:0];
            bin_r <= bin_r + CntW'(1);
          end
          state_r <= last_r ? S_HOLD : S_IDLE;
        end
        S_HOLD: begin
          if (!ov_r || out_tready) state_r <= S_FRAME;
        end
        S_FRAME: begin
          otd_r <= {6'd0, (cd_dec == '0) && (total > thr_r), low_r, high_r, total};
          ov_r  <= 1'b1;
          if ((cd_dec == '0) && (total > thr_r)) cd_r <= cdf_r;
          else cd_r <= cd_dec;
          bin_r   <= '0;
          high_r  <= '0;
          low_r   <= '0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hw/rtl/sfod_checker.sv
// ----------------------------------------------------------------------------
// sfod_checker
// Port-level checks on the onset detector, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sfod_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);
  logic        stall;
  logic [24:0] tot;
  logic [23:0] hi, lo;
  logic        ons;
  assign stall = out_tvalid && !out_tready;
  assign tot   = out_tdata[24:0];
  assign hi    = out_tdata[48:25];
  assign lo    = out_tdata[72:49];
  assign ons   = out_tdata[73];

  `SFOD_ASSERT(a_out_hold, clk, rst_n, stall |=> out_tvalid && $stable(out_tdata), "result lost")
  `SFOD_ASSERT(a_fill, clk, rst_n, out_tvalid |-> out_tdata[79:74] == 6'd0, "fill bits set")
  `SFOD_ASSERT(a_total, clk, rst_n, out_tvalid && !tot[24] |-> tot == hi + lo, "total mismatch")
  `SFOD_ASSERT_ALWAYS(a_rst, clk, !rst_n |=> !out_tvalid && !in_tready, "busy after reset")
  `SFOD_ASSERT(a_onset, clk, rst_n, out_tvalid && ons |-> tot != 25'd0, "onset on zero flux")
endmodule

bind spectral_flux_onset_detector sfod_checker u_sfod_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the spectral flux onset detector: stereo bins go in
// as stream transactions, and a bench-side model predicts the flux and onset
// result of each frame. Every result transaction is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import sfod_pkg::*;

  localparam int FFT_SIZE  = FftSizeDef;
  localparam int LAST_BIN  = FFT_SIZE / 2;
  localparam int DRAIN_CYC = 60;        // margin for the bin still in flight
  localparam logic [AccW-1:0] ACC_SAT = {AccW{1'b1}};
  localparam logic [TotW-1:0] TOT_SAT = {TotW{1'b1}};

  typedef struct {
    logic [TotW-1:0] total;
    logic [AccW-1:0] high;
    logic [AccW-1:0] low;
    logic            onset;
  } flux_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [63:0]         in_tdata = '0;   // left_re, left_im, right_re, right_im
  logic                in_tlast = 1'b0; // frame_end
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [79:0]         out_tdata;       // total, high, low, onset, zero fill
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = CfgThreshold;
  logic [TotW-1:0]     cfg_wdata = '0;

  always #5 clk = ~clk;

  spectral_flux_onset_detector #(.FFT_SIZE(FFT_SIZE)) dut (.*);

  // Bench-side copy of the detector state and its registers
  logic [MagW-1:0] prev_mag [0:LAST_BIN];
  int              bin_idx;
  logic [AccW-1:0] high_acc, low_acc;
  logic [CdW-1:0]  cd_timer;
  logic [TotW-1:0] thresh;
  logic [CdW-1:0]  cd_frames;

  flux_result_t frame_results[$];       // predicted, oldest first

  int  mismatches = 0;
  int  results_seen = 0;
  int  bins_sent = 0;
  int  hold_cycles = 0;                  // receiver hold-off, counted down below
  bit  steady = 1'b0;                    // no idling on either side

  function automatic logic [15:0] int_sqrt(input logic [31:0] v);
    logic [31:0] rem, root, bitv;
    rem = v;
    root = '0;
    bitv = 32'h4000_0000;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root[15:0];
  endfunction

  function automatic logic [15:0] chan_magnitude(input logic signed [15:0] re,
                                                 input logic signed [15:0] im);
    logic [31:0] pwr;
    pwr = 32'(re * re) + 32'(im * im);
    return int_sqrt(pwr);
  endfunction

  function automatic logic [AccW-1:0] acc_add(input logic [AccW-1:0] a,
                                              input logic [MagW-1:0] b);
    logic [AccW:0] s;
    s = a + b;
    return s[AccW] ? ACC_SAT : s[AccW-1:0];
  endfunction

  // Advance the model by one accepted bin; a frame end yields one result.
  task automatic predict_bin(input logic [63:0] d, input logic last);
    logic [MagW-1:0] mag, rise;
    logic [TotW:0]   tsum;
    flux_result_t    r;
    if (bin_idx <= LAST_BIN) begin
      mag = chan_magnitude(d[15:0], d[31:16]) + chan_magnitude(d[47:32], d[63:48]);
      rise = (mag > prev_mag[bin_idx]) ? mag - prev_mag[bin_idx] : '0;
      if (bin_idx >= FFT_SIZE / 4 && bin_idx < LAST_BIN) high_acc = acc_add(high_acc, rise);
      else if (bin_idx >= 1 && bin_idx < FFT_SIZE / 8) low_acc = acc_add(low_acc, rise);
      prev_mag[bin_idx] = mag;
      bin_idx++;
    end
    if (last) begin
      tsum = high_acc + low_acc;
      r.total = (tsum > TOT_SAT) ? TOT_SAT : tsum[TotW-1:0];
      r.high = high_acc;
      r.low = low_acc;
      r.onset = 1'b0;
      if (cd_timer > 0) cd_timer--;
      if (cd_timer == 0 && r.total > thresh) begin
        r.onset = 1'b1;
        cd_timer = cd_frames;
      end
      frame_results.push_back(r);
      bin_idx = 0;
      high_acc = '0;
      low_acc = '0;
    end
  endtask

  // One bin transaction; valid stays high into the next call unless it idles.
  task automatic send_bin(input logic [63:0] d, input logic last);
    if (!steady && $urandom_range(99) < 34) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 34);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    predict_bin(d, last);
    bins_sent++;
  endtask

  // Sender pauses until every predicted result has come back, then the core drains.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // Write enable stays high; the caller drops it after its last write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TotW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CfgThreshold) thresh = val;
    else cd_frames = val[CdW-1:0];
  endtask

  task automatic set_config(input logic [TotW-1:0] th, input logic [CdW-1:0] cd);
    wait_drained();
    write_reg(CfgThreshold, th);
    write_reg(CfgCooldown, TotW'(cd));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_part();
    case ($urandom_range(3))
      0:       return 16'($signed($urandom_range(0, 64)) - 32);  // near zero
      1:       return 16'($signed($urandom_range(0, 4096)) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_bin();
    return {rand_part(), rand_part(), rand_part(), rand_part()};
  endfunction

  // A frame of n bins with random content; frame end on the last one.
  task automatic send_frame(input int n);
    for (int i = 0; i < n; i++) send_bin(rand_bin(), i == n - 1);
  endtask

  // Receiver: random stalls, a counted hold-off when asked, none in steady stretches
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (steady) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 34);
    end
  end

  // Result checker: each result transaction against the oldest prediction
  always @(posedge clk) begin
    flux_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (frame_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", out_tdata);
      end else begin
        exp_r = frame_results.pop_front();
        if (out_tdata[24:0] !== exp_r.total || out_tdata[48:25] !== exp_r.high ||
            out_tdata[72:49] !== exp_r.low || out_tdata[73] !== exp_r.onset) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: total %0d/%0d high %0d/%0d low %0d/%0d onset %0d/%0d (exp/act)",
                     exp_r.total, out_tdata[24:0], exp_r.high, out_tdata[48:25],
                     exp_r.low, out_tdata[72:49], exp_r.onset, out_tdata[73]);
        end
      end
    end
  end

  // Extremes, early frame end, a one-bin frame, no-rise repeat, defaults
  task automatic test_directed();
    send_bin({4{16'h8000}}, 1'b0);                         // bin 0, most negative
    send_bin({4{16'h7FFF}}, 1'b0);                         // low band, largest
    send_bin(64'h0, 1'b0);
    send_bin({16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF}, 1'b0);
    send_bin({16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001}, 1'b1); // early frame end
    send_bin({4{16'h8000}}, 1'b1);                         // one-bin frame
    send_bin({4{16'h8000}}, 1'b0);                         // same magnitudes: no rise
    send_bin({4{16'h7FFF}}, 1'b0);
    send_bin(64'h0, 1'b1);
    send_bin({16'h0000, 16'h0100, 16'h0000, 16'h0100}, 1'b0);
    send_bin({16'h0010, 16'h0000, 16'h0000, 16'h0000}, 1'b1); // tiny flux, under default
  endtask

  // Threshold zero with no cooldown, then the largest of both, then threshold one with the largest cooldown
  task automatic test_config_extremes();
    set_config('0, '0);
    repeat (6) send_frame($urandom_range(2, 8));
    set_config(TOT_SAT, {CdW{1'b1}});
    repeat (4) send_frame($urandom_range(2, 8));
    set_config(TotW'(1), {CdW{1'b1}});
    repeat (4) send_frame($urandom_range(2, 8));
  endtask

  // Receiver holds off long while the sender keeps offering short frames
  task automatic test_backpressure();
    wait_drained();
    hold_cycles = 3000;
    @(posedge clk);
    repeat (8) send_frame($urandom_range(1, 3));
    wait_drained();
  endtask

  // Random phases with random registers: short frames, a full frame with no
  // idling, and an overlong frame whose extra bins are ignored
  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_config(TotW'($urandom_range(0, 200000)), CdW'($urandom_range(0, 4)));
        1: set_config(TotW'($urandom_range(0, 3000)), '0);
        2: set_config(TotW'($urandom_range(50000, 400000)), CdW'($urandom_range(0, 255)));
        default: set_config(TotW'($urandom), CdW'($urandom_range(1, 3)));
      endcase
      steady = (phase == 1);
      case (phase)
        1:       send_frame(LAST_BIN + 1);
        3:       send_frame($urandom_range(LAST_BIN + 2, LAST_BIN + 8));
        default: repeat (3) send_frame($urandom_range(1, 16));
      endcase
      steady = 1'b0;
    end
  endtask

  initial begin
    for (int i = 0; i <= LAST_BIN; i++) prev_mag[i] = '0;
    bin_idx = 0;
    high_acc = '0;
    low_acc = '0;
    cd_timer = '0;
    thresh = ThreshReset;
    cd_frames = CdReset;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random();
    wait_drained();
    if (mismatches == 0 && frame_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
